### design/itgp_pkg.sv
// shared types, constants and width helpers for the ground projection block
`timescale 1ns / 1ps
`default_nettype none

package itgp_pkg;

    // default parameter values
    localparam int DEF_PIXEL_BITS    = 12;
    localparam int DEF_ROT_FRAC_BITS = 16;

    // fixed field widths
    localparam int ROT_ENTRY_BITS = 18;
    localparam int ROT_ROW_BITS   = 3 * ROT_ENTRY_BITS;
    localparam int POS_BITS       = 21;
    localparam int CAM_BITS       = 3 * POS_BITS;
    localparam int CX_BITS        = 16;
    localparam int OC_BITS        = 2 * CX_BITS;
    localparam int F_BITS         = 24;
    localparam int FOCAL_BITS     = 2 * F_BITS;
    localparam int OUT_BITS       = 19;
    localparam int STATUS_BITS    = 2;

    // configuration port
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = CAM_BITS;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ROT_ROW0 = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ROT_ROW1 = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ROT_ROW2 = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CAM_POS  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OPT_CTR  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INV_FOC  = 3'd5;

    // status codes
    localparam logic [STATUS_BITS-1:0] ST_ON_FIELD  = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_ABOVE     = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_OFF_FIELD = 2'd2;

    // field limit and output range
    localparam int FIELD_LIMIT = 142127;
    localparam int LIM_BITS    = 18;
    localparam logic [LIM_BITS-1:0] FIELD_LIMIT_K = LIM_BITS'(FIELD_LIMIT);
    localparam logic signed [OUT_BITS-1:0] OUT_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
    localparam logic signed [OUT_BITS-1:0] OUT_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};

    // queue between front and back
    localparam int QUEUE_DEPTH = 8;
    localparam int FRONT_SLACK = 4;

    // configuration registers
    typedef struct packed {
        logic [ROT_ROW_BITS-1:0] rot0;
        logic [ROT_ROW_BITS-1:0] rot1;
        logic [ROT_ROW_BITS-1:0] rot2;
        logic [CAM_BITS-1:0]     cam;
        logic [OC_BITS-1:0]      ocenter;
        logic [FOCAL_BITS-1:0]   ifocal;
    } t_cfg;

    // queue status towards the front
    typedef struct packed {
        logic empty;
        logic nearly_full;
    } t_qstat;

    // per item flags that travel beside the divider
    typedef struct packed {
        logic valid;
        logic above;
        logic on_field;
        logic negx;
        logic hix;
        logic lox;
        logic negy;
        logic hiy;
        logic loy;
    } t_side;

    // signed width of cx - 16 * px
    function automatic int diff_bits(input int pb);
        return ((pb + 4 > CX_BITS) ? pb + 4 : CX_BITS) + 1;
    endfunction

    // signed width of a ray component
    function automatic int ray_bits(input int pb);
        return diff_bits(pb) + F_BITS + 1 - 4;
    endfunction

    // signed width of a rotated ray component
    function automatic int word_bits(input int pb);
        return ROT_ENTRY_BITS + ray_bits(pb) + 2;
    endfunction

    // one signed entry of a packed rotation row
    function automatic logic signed [ROT_ENTRY_BITS-1:0] rot_entry(
        input logic [ROT_ROW_BITS-1:0] row,
        input int                      j
    );
        return $signed(row[ROT_ENTRY_BITS*j +: ROT_ENTRY_BITS]);
    endfunction

endpackage

`default_nettype wire

### design/itgp_queue.sv
// short item queue between the front and the back
`timescale 1ns / 1ps
`default_nettype none

module itgp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = itgp_pkg::QUEUE_DEPTH,
    parameter int SLACK = itgp_pkg::FRONT_SLACK
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output itgp_pkg::t_qstat      o_stat
);
    import itgp_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_count;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_data             = r_mem[r_rd];
    assign o_stat.empty       = (r_count == '0);
    assign o_stat.nearly_full = (r_count >= CW'(DEPTH - SLACK));

    // checks
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && !i_pop && r_count == CW'(DEPTH)))
        else $error("item pushed into a full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("item popped from an empty queue");
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("queue level did not follow a push");

endmodule

`default_nettype wire

### design/itgp_front.sv
// front: view ray, rotation and horizon classification of each item
`timescale 1ns / 1ps
`default_nettype none

module itgp_front #(
    parameter int PIXEL_BITS    = itgp_pkg::DEF_PIXEL_BITS,
    parameter int ROT_FRAC_BITS = itgp_pkg::DEF_ROT_FRAC_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire itgp_pkg::t_cfg        i_cfg,
    input  wire logic                  i_valid,
    input  wire logic [PIXEL_BITS-1:0] i_pixel_x,
    input  wire logic [PIXEL_BITS-1:0] i_pixel_y,
    output logic                       o_valid,
    output logic signed [itgp_pkg::word_bits(PIXEL_BITS)-1:0] o_w0,
    output logic signed [itgp_pkg::word_bits(PIXEL_BITS)-1:0] o_w1,
    output logic signed [itgp_pkg::word_bits(PIXEL_BITS)-1:0] o_w2,
    output logic                       o_above
);
    import itgp_pkg::*;

    localparam int DW  = diff_bits(PIXEL_BITS);
    localparam int PW  = DW + F_BITS + 1;
    localparam int VW  = ray_bits(PIXEL_BITS);
    localparam int RPW = ROT_ENTRY_BITS + VW;
    localparam int WW  = word_bits(PIXEL_BITS);

    logic [CX_BITS-1:0]      s_cx;
    logic [CX_BITS-1:0]      s_cy;
    logic [F_BITS-1:0]       s_fx;
    logic [F_BITS-1:0]       s_fy;
    logic signed [DW-1:0]    s_dx;
    logic signed [DW-1:0]    s_dy;
    logic signed [VW-1:0]    s_v1;
    logic signed [VW-1:0]    s_v2;
    logic [ROT_ROW_BITS-1:0] s_rows [3];
    logic [F_BITS+2:0]       s_fy5;
    logic signed [WW-1:0]    s_thr;

    logic                    r1_v;
    logic signed [PW-1:0]    r1_prx;
    logic signed [PW-1:0]    r1_pry;
    logic                    r2_v;
    logic signed [RPW-1:0]   r2_p [3][3];
    logic                    r3_v;
    logic signed [WW-1:0]    r3_w [3];

    assign s_cx    = i_cfg.ocenter[CX_BITS-1:0];
    assign s_cy    = i_cfg.ocenter[OC_BITS-1:CX_BITS];
    assign s_fx    = i_cfg.ifocal[F_BITS-1:0];
    assign s_fy    = i_cfg.ifocal[FOCAL_BITS-1:F_BITS];
    assign s_rows[0] = i_cfg.rot0;
    assign s_rows[1] = i_cfg.rot1;
    assign s_rows[2] = i_cfg.rot2;

    // offset from the optical centre in q.4 pixels
    assign s_dx = DW'(s_cx) - DW'({i_pixel_x, 4'b0000});
    assign s_dy = DW'(s_cy) - DW'({i_pixel_y, 4'b0000});

    // floor of the scaled offset gives the ray in q.24
    assign s_v1 = VW'(r1_prx >>> 4);
    assign s_v2 = VW'(r1_pry >>> 4);

    // stage 1: offset times inverse focal length
    always_ff @(posedge i_clk) begin
        r1_prx <= s_dx * $signed({1'b0, s_fx});
        r1_pry <= s_dy * $signed({1'b0, s_fy});
    end

    // stage 2: rotation products, the forward component is exactly one
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r2_p[i][0] <= RPW'(rot_entry(s_rows[i], 0)) <<< F_BITS;
            r2_p[i][1] <= rot_entry(s_rows[i], 1) * s_v1;
            r2_p[i][2] <= rot_entry(s_rows[i], 2) * s_v2;
        end
    end

    // stage 3: row sums
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r3_w[i] <= WW'(r2_p[i][0]) + WW'(r2_p[i][1]) + WW'(r2_p[i][2]);
        end
    end

    // item valid through the stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    // horizon limit -5 * fy in the rotated format
    assign s_fy5 = {1'b0, s_fy, 2'b00} + (F_BITS + 3)'(s_fy);
    assign s_thr = -$signed(WW'(s_fy5) << ROT_FRAC_BITS);

    assign o_valid = r3_v;
    assign o_w0    = r3_w[0];
    assign o_w1    = r3_w[1];
    assign o_w2    = r3_w[2];
    assign o_above = (r3_w[2] >= 0) || (r3_w[2] > s_thr);

endmodule

`default_nettype wire

### design/itgp_div.sv
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none

module itgp_div #(
    parameter int NW   = 82,
    parameter int DENW = 63
) (
    input  wire logic                          i_clk,
    input  wire logic [NW-1:0]                 i_num,
    input  wire logic [DENW-1:0]               i_den,
    output logic [itgp_pkg::OUT_BITS-1:0]      o_quot
);
    import itgp_pkg::*;

    localparam int QB = OUT_BITS;

    logic [NW-1:0]   r_num [QB];
    logic [DENW-1:0] r_den [QB];
    logic [QB-1:0]   r_q   [QB];
    logic [NW-1:0]   s_num [QB];
    logic [DENW-1:0] s_den [QB];
    logic [QB-1:0]   s_q   [QB];
    logic [NW-1:0]   s_sub [QB];
    logic            s_take [QB];

    // trial subtraction of the shifted divisor in every stage
    always_comb begin
        for (int k = 0; k < QB; k++) begin
            s_num[k]  = (k == 0) ? i_num : r_num[(k == 0) ? 0 : k - 1];
            s_den[k]  = (k == 0) ? i_den : r_den[(k == 0) ? 0 : k - 1];
            s_q[k]    = (k == 0) ? '0    : r_q[(k == 0) ? 0 : k - 1];
            s_sub[k]  = NW'(s_den[k]) << (QB - 1 - k);
            s_take[k] = (s_num[k] >= s_sub[k]);
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < QB; k++) begin
            r_num[k] <= s_take[k] ? s_num[k] - s_sub[k] : s_num[k];
            r_den[k] <= s_den[k];
            r_q[k]   <= s_q[k] | (QB'(s_take[k]) << (QB - 1 - k));
        end
    end

    assign o_quot = r_q[QB-1];

endmodule

`default_nettype wire

### design/itgp_back.sv
// back: plane intersection, field check, rounding division and saturation
`timescale 1ns / 1ps
`default_nettype none

module itgp_back #(
    parameter int PIXEL_BITS = itgp_pkg::DEF_PIXEL_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire itgp_pkg::t_cfg       i_cfg,
    input  wire logic                 i_valid,
    input  wire logic                 i_above,
    input  wire logic signed [itgp_pkg::word_bits(PIXEL_BITS)-1:0] i_w0,
    input  wire logic signed [itgp_pkg::word_bits(PIXEL_BITS)-1:0] i_w1,
    input  wire logic signed [itgp_pkg::word_bits(PIXEL_BITS)-1:0] i_w2,
    output logic                      o_strobe,
    output logic signed [itgp_pkg::OUT_BITS-1:0]    o_ground_x,
    output logic signed [itgp_pkg::OUT_BITS-1:0]    o_ground_y,
    output logic [itgp_pkg::STATUS_BITS-1:0]        o_status
);
    import itgp_pkg::*;

    localparam int WW    = word_bits(PIXEL_BITS);
    localparam int WL    = WW / 2;
    localparam int WH    = WW - WL;
    localparam int HPW   = POS_BITS + WH;
    localparam int LPW   = POS_BITS + WL + 1;
    localparam int PRW   = POS_BITS + WW;
    localparam int MW    = PRW + 1;
    localparam int DLW   = WW + 4;
    localparam int DL    = DLW / 2;
    localparam int DH    = DLW - DL;
    localparam int LIMW  = LIM_BITS + DLW;
    localparam int CW    = LIMW + 1;
    localparam int NUMW  = MW + 2;
    localparam int DENW  = DLW + 1;
    localparam int QB    = OUT_BITS;

    logic signed [POS_BITS-1:0] s_a1;
    logic signed [POS_BITS-1:0] s_a2;
    logic signed [POS_BITS-1:0] s_a3;
    logic signed [WW-1:0]       s_nw2;

    // stage 1 registers
    logic                 r1_v;
    logic                 r1_above;
    logic signed [HPW-1:0] r1_h3x, r1_h1x, r1_h3y, r1_h2y;
    logic signed [LPW-1:0] r1_l3x, r1_l1x, r1_l3y, r1_l2y;
    logic [DLW-1:0]       r1_d;
    // stage 2 registers
    logic                 r2_v;
    logic                 r2_above;
    logic signed [PRW-1:0] r2_p3x, r2_p1x, r2_p3y, r2_p2y;
    logic [LIM_BITS+DH-1:0] r2_limh;
    logic [LIM_BITS+DL-1:0] r2_liml;
    logic [DLW-1:0]       r2_d;
    // stage 3 registers
    logic                 r3_v;
    logic                 r3_above;
    logic signed [MW-1:0] r3_mx, r3_my;
    logic [LIMW-1:0]      r3_lim;
    logic [DLW-1:0]       r3_d;
    // stage 4 registers
    logic                 r4_v;
    logic                 r4_above;
    logic                 r4_on_field;
    logic signed [NUMW-1:0] r4_numx, r4_numy;
    logic [DLW-1:0]       r4_d;
    // stage 5 registers
    t_side                r5_side;
    logic [NUMW-1:0]      r5_divx, r5_divy;
    logic [DENW-1:0]      r5_den;
    // flags beside the divider and the output register
    t_side                r_side [QB];
    logic                 r_strobe;
    logic signed [OUT_BITS-1:0] r_gx, r_gy;
    logic [STATUS_BITS-1:0] r_status;

    logic signed [CW-1:0]   s_mxc, s_myc, s_limc;
    logic                   s_inx, s_iny;
    logic [DENW-1:0]        s_den;
    logic signed [NUMW-1:0] s_cap;
    logic signed [NUMW-1:0] s_sumx, s_sumy;
    logic [OUT_BITS-1:0]    s_qx, s_qy;
    t_side                  s_out;

    assign s_a1  = $signed(i_cfg.cam[POS_BITS-1:0]);
    assign s_a2  = $signed(i_cfg.cam[2*POS_BITS-1:POS_BITS]);
    assign s_a3  = $signed(i_cfg.cam[3*POS_BITS-1:2*POS_BITS]);
    assign s_nw2 = -i_w2;

    // stage 1: camera offsets times the ray, each split into two halves
    always_ff @(posedge i_clk) begin
        r1_h3x <= s_a3 * $signed(i_w0[WW-1:WL]);
        r1_l3x <= s_a3 * $signed({1'b0, i_w0[WL-1:0]});
        r1_h1x <= s_a1 * $signed(i_w2[WW-1:WL]);
        r1_l1x <= s_a1 * $signed({1'b0, i_w2[WL-1:0]});
        r1_h3y <= s_a3 * $signed(i_w1[WW-1:WL]);
        r1_l3y <= s_a3 * $signed({1'b0, i_w1[WL-1:0]});
        r1_h2y <= s_a2 * $signed(i_w2[WW-1:WL]);
        r1_l2y <= s_a2 * $signed({1'b0, i_w2[WL-1:0]});
        r1_d   <= DLW'($unsigned(s_nw2)) << 4;
    end

    // stage 2: join the halves, field limit partial products
    always_ff @(posedge i_clk) begin
        r2_p3x  <= (PRW'(r1_h3x) <<< WL) + PRW'(r1_l3x);
        r2_p1x  <= (PRW'(r1_h1x) <<< WL) + PRW'(r1_l1x);
        r2_p3y  <= (PRW'(r1_h3y) <<< WL) + PRW'(r1_l3y);
        r2_p2y  <= (PRW'(r1_h2y) <<< WL) + PRW'(r1_l2y);
        r2_limh <= FIELD_LIMIT_K * r1_d[DLW-1:DL];
        r2_liml <= FIELD_LIMIT_K * r1_d[DL-1:0];
        r2_d    <= r1_d;
    end

    // stage 3: ground numerators and the field limit times the divisor
    always_ff @(posedge i_clk) begin
        r3_mx  <= MW'(r2_p3x) - MW'(r2_p1x);
        r3_my  <= MW'(r2_p3y) - MW'(r2_p2y);
        r3_lim <= (LIMW'(r2_limh) << DL) + LIMW'(r2_liml);
        r3_d   <= r2_d;
    end

    // field check on the exact numerators
    assign s_mxc  = CW'(r3_mx);
    assign s_myc  = CW'(r3_my);
    assign s_limc = CW'(r3_lim);
    assign s_inx  = (s_mxc < s_limc) && ((s_mxc + s_limc) > 0);
    assign s_iny  = (s_myc < s_limc) && ((s_myc + s_limc) > 0);

    // stage 4: rounding offset, numerator 2m + d over 2d
    always_ff @(posedge i_clk) begin
        r4_numx     <= (NUMW'(r3_mx) <<< 1) + $signed(NUMW'(r3_d));
        r4_numy     <= (NUMW'(r3_my) <<< 1) + $signed(NUMW'(r3_d));
        r4_on_field <= s_inx && s_iny;
        r4_d        <= r3_d;
    end

    // saturation limits and divider operands
    assign s_den  = {r4_d, 1'b0};
    assign s_cap  = $signed(NUMW'(s_den) << (OUT_BITS - 1));
    assign s_sumx = r4_numx + s_cap;
    assign s_sumy = r4_numy + s_cap;

    // stage 5: magnitude dividend, negative side rounds up
    always_ff @(posedge i_clk) begin
        r5_divx <= r4_numx[NUMW-1] ? NUMW'(s_den) + ~r4_numx : r4_numx;
        r5_divy <= r4_numy[NUMW-1] ? NUMW'(s_den) + ~r4_numy : r4_numy;
        r5_den  <= s_den;
    end

    // stage 5: item flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_side <= '0;
        end else begin
            r5_side.valid    <= r4_v;
            r5_side.above    <= r4_above;
            r5_side.on_field <= r4_on_field;
            r5_side.negx     <= r4_numx[NUMW-1];
            r5_side.hix      <= !r4_numx[NUMW-1] && (r4_numx >= s_cap);
            r5_side.lox      <= r4_numx[NUMW-1] && s_sumx[NUMW-1];
            r5_side.negy     <= r4_numy[NUMW-1];
            r5_side.hiy      <= !r4_numy[NUMW-1] && (r4_numy >= s_cap);
            r5_side.loy      <= r4_numy[NUMW-1] && s_sumy[NUMW-1];
        end
    end

    // valid and horizon flag through the arithmetic stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_above <= i_above;
        r2_above <= r1_above;
        r3_above <= r2_above;
        r4_above <= r3_above;
    end

    // dividers for both axes
    itgp_div #(
        .NW   (NUMW),
        .DENW (DENW)
    ) u_div_x (
        .i_clk  (i_clk),
        .i_num  (r5_divx),
        .i_den  (r5_den),
        .o_quot (s_qx)
    );

    itgp_div #(
        .NW   (NUMW),
        .DENW (DENW)
    ) u_div_y (
        .i_clk  (i_clk),
        .i_num  (r5_divy),
        .i_den  (r5_den),
        .o_quot (s_qy)
    );

    // item flags ride along with the divider
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < QB; k++) begin
                r_side[k] <= '0;
            end
        end else begin
            r_side[0] <= r5_side;
            for (int k = 1; k < QB; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign s_out = r_side[QB-1];

    // output register: sign, saturation and status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= s_out.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (s_out.above) begin
            r_gx     <= '0;
            r_gy     <= '0;
            r_status <= ST_ABOVE;
        end else begin
            priority if (s_out.hix)  r_gx <= OUT_MAX;
            else if (s_out.lox)      r_gx <= OUT_MIN;
            else if (s_out.negx)     r_gx <= $signed(-s_qx);
            else                     r_gx <= $signed(s_qx);
            priority if (s_out.hiy)  r_gy <= OUT_MAX;
            else if (s_out.loy)      r_gy <= OUT_MIN;
            else if (s_out.negy)     r_gy <= $signed(-s_qy);
            else                     r_gy <= $signed(s_qy);
            r_status <= s_out.on_field ? ST_ON_FIELD : ST_OFF_FIELD;
        end
    end

    assign o_strobe   = r_strobe;
    assign o_ground_x = r_gx;
    assign o_ground_y = r_gy;
    assign o_status   = r_status;

endmodule

`default_nettype wire

### design/image_to_ground_projection.sv
// top level: configuration registers, front, item queue and back
`timescale 1ns / 1ps
`default_nettype none

// Projects one image pixel per clock onto the ground plane while busy is low.
// An item is taken at every edge with start high and busy low, and its
// result shows on the output ports for exactly one cycle, marked by o_strobe;
// the results leave in the order the items came. Each item passes three
// front stages of ray and rotation multiplies, the item queue, five stages
// of intersection arithmetic and the 19-stage restoring divider that forms
// the rounded millimetre values. The back never
// stalls, so the queue between front and back stays nearly empty and busy
// stays low in normal use. Configuration writes take effect at once and are
// meant for times when no item is in flight.
module image_to_ground_projection #(
    parameter int PIXEL_BITS    = itgp_pkg::DEF_PIXEL_BITS,
    parameter int ROT_FRAC_BITS = itgp_pkg::DEF_ROT_FRAC_BITS
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic [PIXEL_BITS-1:0]                 i_pixel_x,
    input  wire logic [PIXEL_BITS-1:0]                 i_pixel_y,
    input  wire logic                                  i_cfg_we,
    input  wire logic [itgp_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  wire logic [itgp_pkg::CFG_DATA_BITS-1:0]    i_cfg_wdata,
    output logic                                       o_strobe,
    output logic signed [itgp_pkg::OUT_BITS-1:0]       o_ground_x,
    output logic signed [itgp_pkg::OUT_BITS-1:0]       o_ground_y,
    output logic [itgp_pkg::STATUS_BITS-1:0]           o_status
);
    import itgp_pkg::*;

    localparam int WW = word_bits(PIXEL_BITS);
    localparam int QW = 3 * WW + 1;

    t_cfg                 r_cfg;
    t_qstat               s_qstat;
    logic                 s_accept;
    logic                 s_f_valid;
    logic                 s_f_above;
    logic signed [WW-1:0] s_f_w0, s_f_w1, s_f_w2;
    logic [QW-1:0]        s_q_wdata;
    logic [QW-1:0]        s_q_rdata;
    logic                 s_pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ROT_ROW0: r_cfg.rot0    <= i_cfg_wdata[ROT_ROW_BITS-1:0];
                CFG_ROT_ROW1: r_cfg.rot1    <= i_cfg_wdata[ROT_ROW_BITS-1:0];
                CFG_ROT_ROW2: r_cfg.rot2    <= i_cfg_wdata[ROT_ROW_BITS-1:0];
                CFG_CAM_POS:  r_cfg.cam     <= i_cfg_wdata[CAM_BITS-1:0];
                CFG_OPT_CTR:  r_cfg.ocenter <= i_cfg_wdata[OC_BITS-1:0];
                CFG_INV_FOC:  r_cfg.ifocal  <= i_cfg_wdata[FOCAL_BITS-1:0];
                default: ;
            endcase
        end
    end

    // item intake
    assign busy     = s_qstat.nearly_full;
    assign s_accept = start && !busy;

    itgp_front #(
        .PIXEL_BITS    (PIXEL_BITS),
        .ROT_FRAC_BITS (ROT_FRAC_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (s_accept),
        .i_pixel_x (i_pixel_x),
        .i_pixel_y (i_pixel_y),
        .o_valid   (s_f_valid),
        .o_w0      (s_f_w0),
        .o_w1      (s_f_w1),
        .o_w2      (s_f_w2),
        .o_above   (s_f_above)
    );

    // queue between front and back
    assign s_q_wdata = {s_f_above, s_f_w2, s_f_w1, s_f_w0};
    assign s_pop     = !s_qstat.empty;

    itgp_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH),
        .SLACK (FRONT_SLACK)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_f_valid),
        .i_data  (s_q_wdata),
        .i_pop   (s_pop),
        .o_data  (s_q_rdata),
        .o_stat  (s_qstat)
    );

    itgp_back #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (s_pop),
        .i_above    (s_q_rdata[QW-1]),
        .i_w0       ($signed(s_q_rdata[WW-1:0])),
        .i_w1       ($signed(s_q_rdata[2*WW-1:WW])),
        .i_w2       ($signed(s_q_rdata[3*WW-1:2*WW])),
        .o_strobe   (o_strobe),
        .o_ground_x (o_ground_x),
        .o_ground_y (o_ground_y),
        .o_status   (o_status)
    );

    // checks
    a_quiet_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("result strobe right after reset");
    a_above_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == ST_ABOVE) |-> (o_ground_x == '0 && o_ground_y == '0))
        else $error("above-horizon item with a non-zero position");
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_status == ST_ON_FIELD || o_status == ST_ABOVE
                      || o_status == ST_OFF_FIELD))
        else $error("unused status code on a result");
    a_on_field_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == ST_ON_FIELD) |->
        (o_ground_x <= FIELD_LIMIT && o_ground_x >= -FIELD_LIMIT
         && o_ground_y <= FIELD_LIMIT && o_ground_y >= -FIELD_LIMIT))
        else $error("on-field item outside the field limit");

endmodule

`default_nettype wire
